[rtl/core/cosine_nearest_entry_cache_top_macros.svh]
// Assertion macros shared by the checker of the cosine nearest-entry cache.
`ifndef COSINE_NEAREST_ENTRY_CACHE_TOP_MACROS_SVH
`define COSINE_NEAREST_ENTRY_CACHE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CNEC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cnec check failed");

// Next-cycle implication, disabled while reset is low.
`define CNEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cnec check failed");

`endif

[rtl/core/cnec_pkg.sv]
// Package: types, widths and codes of the cosine nearest-entry cache.
package cnec_pkg;

    localparam int CAPACITY  = 64;
    localparam int EMBED_DIM = 64;

    localparam int LOG_DIM   = $clog2(EMBED_DIM);
    localparam int IDX_W     = (EMBED_DIM > 1) ? LOG_DIM : 1;
    localparam int POS_W     = $clog2(EMBED_DIM + 1);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int MEM_DEPTH = CAPACITY * EMBED_DIM;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int BASE_W    = $clog2(MEM_DEPTH + 1);

    // Accumulator width, kept even so the root unit walks whole bit pairs.
    localparam int ACC_W  = ((LOG_DIM % 2) == 0) ? (34 + LOG_DIM) : (35 + LOG_DIM);
    localparam int RT_W   = ACC_W / 2;
    localparam int DEN_W  = ACC_W + 1;
    localparam int NUM_W  = ACC_W + 17;

    localparam logic [1:0] KIND_STORE = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [2:0] OUT_STORED  = 3'd0;
    localparam logic [2:0] OUT_DROPPED = 3'd1;
    localparam logic [2:0] OUT_MISS    = 3'd2;
    localparam logic [2:0] OUT_HIT     = 3'd3;
    localparam logic [2:0] OUT_CLEARED = 3'd4;

    localparam logic signed [15:0] THR_RESET = 16'sd29491;
    localparam logic signed [15:0] SIM_MIN   = -16'sd32768;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] element_value;
        logic               last_element;
    } t_req;

    typedef struct packed {
        logic [2:0]         outcome;
        logic [6:0]         slot;
        logic signed [15:0] similarity;
        logic [31:0]        hit_count;
        logic [31:0]        miss_count;
        logic [31:0]        drop_count;
    } t_res;

endpackage

[rtl/core/cnec_sqrt.sv]
// Iterative floor square root, one bit pair per cycle.
module cnec_sqrt
    import cnec_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ACC_W-1:0] i_val,
    output logic             o_done,
    output logic [RT_W-1:0]  o_root
);

    logic             r_busy;
    logic             r_done;
    logic [ACC_W-1:0] r_v;
    logic [ACC_W-1:0] r_r;
    logic [ACC_W-1:0] r_bit;
    logic [ACC_W-1:0] w_sum;

    assign w_sum  = r_r + r_bit;
    assign o_done = r_done;
    assign o_root = r_r[RT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_r   <= '0;
            r_bit <= ACC_W'(1) << (ACC_W - 2);
        end else if (r_busy) begin
            if (r_v >= w_sum) begin
                r_v <= r_v - w_sum;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

endmodule

[rtl/core/cnec_div.sv]
// Restoring divider, one quotient bit per cycle.
module cnec_div
    import cnec_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_q;
    logic [DEN_W:0]    w_trial;
    logic              w_fit;

    assign w_trial = {r_rem, r_q[NUM_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quo   = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= i_num;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= DEN_W'(w_trial - {1'b0, r_den});
            end else begin
                r_rem <= w_trial[DEN_W-1:0];
            end
            r_q <= {r_q[NUM_W-2:0], w_fit};
        end
    end

endmodule

[rtl/core/cosine_nearest_entry_cache_top.sv]
// Top level: vector store, query buffer and search sequencer of the cosine cache.
// A non-last element gives no result; a last store answers once any zero-fill of the
//   remaining positions is done; a clear answers in the next cycle.
// A query search visits each stored entry in turn: a walk of the store memory at one
//   read per cycle, then the root units and, unless a norm is zero, the divider.
// busy stays high during fill and search; results are one-cycle strobes and cannot stall.
// Reset (synchronous, active low) empties the store and zeroes all counters; no clearing pass.
module cosine_nearest_entry_cache_top
    import cnec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  t_req               i_req,
    output logic               busy,
    output logic               o_res_valid,
    output t_res               o_res,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic signed [15:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FILL = 4'd1;
    localparam logic [3:0] S_SRCH = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_ROOT = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_DIV0 = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_NEXT = 4'd8;

    // Memories: packed vector store and the query vector being gathered.
    logic signed [15:0] m_store [MEM_DEPTH];
    logic signed [15:0] m_qbuf  [EMBED_DIM];

    // Control state.
    logic [3:0]         r_state;
    logic [POS_W-1:0]   r_pos;
    logic [CNT_W-1:0]   r_count;
    logic [BASE_W-1:0]  r_wbase;
    logic               r_fill_q;
    logic signed [15:0] r_thr;
    logic [31:0]        r_hits;
    logic [31:0]        r_misses;
    logic [31:0]        r_drops;
    logic               r_res_v;
    t_res               r_res;

    // Search state.
    logic [CNT_W-1:0]   r_ent;
    logic [BASE_W-1:0]  r_sbase;
    logic [POS_W-1:0]   r_cnt;
    logic               r_rd_v;
    logic               r_pr_v;
    logic signed [15:0] r_best;
    logic [CNT_W-1:0]   r_best_slot;

    // Datapath.
    logic signed [15:0]      r_qd;
    logic signed [15:0]      r_ed;
    logic signed [31:0]      r_pd;
    logic signed [31:0]      r_pa;
    logic signed [31:0]      r_pb;
    logic signed [ACC_W-1:0] r_dot;
    logic signed [ACC_W-1:0] r_na;
    logic signed [ACC_W-1:0] r_nb;
    logic [RT_W-1:0]         r_ra;
    logic [RT_W-1:0]         r_rb;
    logic [ACC_W-1:0]        r_den;
    logic signed [15:0]      r_sim;

    logic               w_acc;
    logic               w_room;
    logic [POS_W-1:0]   w_pos_inc;
    logic               w_st_we;
    logic [BASE_W-1:0]  w_st_full;
    logic signed [15:0] w_st_wd;
    logic               w_q_we;
    logic signed [15:0] w_q_wd;
    logic [BASE_W-1:0]  w_rd_full;
    logic               w_scan_end;
    logic               w_scan_go;
    logic               w_last_ent;
    logic               w_better;
    logic signed [15:0] w_best;
    logic [CNT_W-1:0]   w_best_slot;
    logic [31:0]        w_hits_inc;
    logic [31:0]        w_misses_inc;
    logic               w_sqa_done;
    logic               w_sqb_done;
    logic [RT_W-1:0]    w_ra;
    logic [RT_W-1:0]    w_rb;
    logic               w_dv_start;
    logic               w_dv_done;
    logic [NUM_W-1:0]   w_quo;
    logic [ACC_W-1:0]   w_mag;
    logic [NUM_W-1:0]   w_num;
    logic signed [15:0] w_sat;
    logic [ACC_W-1:0]   w_den;

    function automatic t_res f_res(input logic [2:0] outcome, input logic [6:0] slot,
                                   input logic signed [15:0] sim, input logic [31:0] hits,
                                   input logic [31:0] misses, input logic [31:0] drops);
        t_res v;
        v.outcome    = outcome;
        v.slot       = slot;
        v.similarity = sim;
        v.hit_count  = hits;
        v.miss_count = misses;
        v.drop_count = drops;
        return v;
    endfunction

    assign busy        = r_state != S_IDLE;
    assign o_res_valid = r_res_v;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

    assign w_acc     = start && (r_state == S_IDLE);
    assign w_room    = r_count < CNT_W'(CAPACITY);
    assign w_pos_inc = (r_pos < POS_W'(EMBED_DIM)) ? (r_pos + 1'b1) : r_pos;

    // Store writes: the element itself on a request, zeros during the fill sweep.
    assign w_st_we   = (w_acc && i_req.kind == KIND_STORE && w_room
                        && r_pos < POS_W'(EMBED_DIM))
                       || (r_state == S_FILL && !r_fill_q);
    assign w_st_full = r_wbase + BASE_W'(r_pos);
    assign w_st_wd   = (r_state == S_FILL) ? 16'sd0 : i_req.element_value;
    assign w_q_we    = (w_acc && i_req.kind == KIND_QUERY && r_pos < POS_W'(EMBED_DIM))
                       || (r_state == S_FILL && r_fill_q);
    assign w_q_wd    = (r_state == S_FILL) ? 16'sd0 : i_req.element_value;
    assign w_rd_full = r_sbase + BASE_W'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (w_st_we) begin
            m_store[w_st_full[ADDR_W-1:0]] <= w_st_wd;
        end
        r_ed <= m_store[w_rd_full[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_q_we) begin
            m_qbuf[r_pos[IDX_W-1:0]] <= w_q_wd;
        end
        r_qd <= m_qbuf[r_cnt[IDX_W-1:0]];
    end

    // Scan is complete once all reads were issued and the product pipe has drained.
    assign w_scan_end = (r_state == S_SCAN) && (r_cnt == POS_W'(EMBED_DIM))
                        && !r_rd_v && !r_pr_v;
    assign w_last_ent = r_ent == (r_count - 1'b1);
    assign w_scan_go  = ((r_state == S_SRCH) && (r_count != '0))
                        || ((r_state == S_NEXT) && !w_last_ent);
    assign w_dv_start = (r_state == S_DIV0) && (r_na != '0) && (r_nb != '0);

    // First strict maximum wins.
    assign w_better    = r_sim > r_best;
    assign w_best      = w_better ? r_sim : r_best;
    assign w_best_slot = w_better ? r_ent : r_best_slot;
    assign w_hits_inc   = r_hits + 32'd1;
    assign w_misses_inc = r_misses + 32'd1;

    // Rounded quotient: (|d| * 2^16 + den) / (2 * den).
    assign w_mag = r_dot[ACC_W-1] ? ACC_W'(-r_dot) : ACC_W'(r_dot);
    assign w_num = {w_mag, 16'd0} + NUM_W'(r_den);

    // Product of the two roots at full width.
    assign w_den = r_ra * r_rb;

    always_comb begin
        if (!r_dot[ACC_W-1]) begin
            w_sat = (w_quo > NUM_W'(32767)) ? 16'sd32767 : 16'(w_quo);
        end else begin
            w_sat = (w_quo > NUM_W'(32768)) ? SIM_MIN : 16'(~w_quo + 1'b1);
        end
    end

    cnec_sqrt u_sqrt_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_scan_end),
        .i_val   (ACC_W'(r_na)),
        .o_done  (w_sqa_done),
        .o_root  (w_ra)
    );

    cnec_sqrt u_sqrt_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_scan_end),
        .i_val   (ACC_W'(r_nb)),
        .o_done  (w_sqb_done),
        .o_root  (w_rb)
    );

    cnec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_num   (w_num),
        .i_den   ({r_den, 1'b0}),
        .o_done  (w_dv_done),
        .o_quo   (w_quo)
    );

    // Multiply-accumulate pipe: read, product, sum.
    always_ff @(posedge i_clk) begin
        r_pd <= r_qd * r_ed;
        r_pa <= r_qd * r_qd;
        r_pb <= r_ed * r_ed;
        if (w_scan_go) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
        end else if (r_pr_v) begin
            r_dot <= r_dot + ACC_W'(r_pd);
            r_na  <= r_na + ACC_W'(r_pa);
            r_nb  <= r_nb + ACC_W'(r_pb);
        end
        if (w_sqa_done) begin
            r_ra <= w_ra;
        end
        if (w_sqb_done) begin
            r_rb <= w_rb;
        end
        if (r_state == S_MUL) begin
            r_den <= w_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_count     <= '0;
            r_wbase     <= '0;
            r_fill_q    <= 1'b0;
            r_thr       <= THR_RESET;
            r_hits      <= '0;
            r_misses    <= '0;
            r_drops     <= '0;
            r_res_v     <= 1'b0;
            r_ent       <= '0;
            r_sbase     <= '0;
            r_cnt       <= '0;
            r_rd_v      <= 1'b0;
            r_pr_v      <= 1'b0;
            r_best      <= SIM_MIN;
            r_best_slot <= '0;
            r_sim       <= '0;
        end else begin
            r_res_v <= 1'b0;
            r_rd_v  <= (r_state == S_SCAN) && (r_cnt < POS_W'(EMBED_DIM));
            r_pr_v  <= r_rd_v;
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (w_scan_go) begin
                r_cnt <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        case (i_req.kind)
                            KIND_STORE: begin
                                if (!i_req.last_element) begin
                                    r_pos <= w_pos_inc;
                                end else if (!w_room) begin
                                    // Full: drop the vector and count it.
                                    r_pos   <= '0;
                                    r_drops <= r_drops + 32'd1;
                                    r_res_v <= 1'b1;
                                    r_res   <= f_res(OUT_DROPPED, 7'(CAPACITY), 16'sd0,
                                                     r_hits, r_misses, r_drops + 32'd1);
                                end else if (w_pos_inc < POS_W'(EMBED_DIM)) begin
                                    r_pos    <= w_pos_inc;
                                    r_fill_q <= 1'b0;
                                    r_state  <= S_FILL;
                                end else begin
                                    r_pos   <= '0;
                                    r_count <= r_count + 1'b1;
                                    r_wbase <= r_wbase + BASE_W'(EMBED_DIM);
                                    r_res_v <= 1'b1;
                                    r_res   <= f_res(OUT_STORED, 7'(r_count), 16'sd0,
                                                     r_hits, r_misses, r_drops);
                                end
                            end
                            KIND_QUERY: begin
                                if (!i_req.last_element) begin
                                    r_pos <= w_pos_inc;
                                end else if (w_pos_inc < POS_W'(EMBED_DIM)) begin
                                    r_pos    <= w_pos_inc;
                                    r_fill_q <= 1'b1;
                                    r_state  <= S_FILL;
                                end else begin
                                    r_pos   <= '0;
                                    r_state <= S_SRCH;
                                end
                            end
                            KIND_CLEAR: begin
                                r_pos   <= '0;
                                r_count <= '0;
                                r_wbase <= '0;
                                r_drops <= '0;
                                r_res_v <= 1'b1;
                                r_res   <= f_res(OUT_CLEARED, 7'd0, 16'sd0,
                                                 r_hits, r_misses, 32'd0);
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_FILL: begin
                    // Zero the tail of a short vector, one position a cycle.
                    if (r_pos == POS_W'(EMBED_DIM - 1)) begin
                        r_pos <= '0;
                        if (r_fill_q) begin
                            r_state <= S_SRCH;
                        end else begin
                            r_state <= S_IDLE;
                            r_count <= r_count + 1'b1;
                            r_wbase <= r_wbase + BASE_W'(EMBED_DIM);
                            r_res_v <= 1'b1;
                            r_res   <= f_res(OUT_STORED, 7'(r_count), 16'sd0,
                                             r_hits, r_misses, r_drops);
                        end
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_SRCH: begin
                    r_ent       <= '0;
                    r_sbase     <= '0;
                    r_best      <= SIM_MIN;
                    r_best_slot <= '0;
                    if (r_count == '0) begin
                        r_state  <= S_IDLE;
                        r_misses <= w_misses_inc;
                        r_res_v  <= 1'b1;
                        r_res    <= f_res(OUT_MISS, 7'd0, SIM_MIN,
                                          r_hits, w_misses_inc, r_drops);
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cnt < POS_W'(EMBED_DIM)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (w_scan_end) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (w_sqa_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV0;
                end
                S_DIV0: begin
                    if (w_dv_start) begin
                        r_state <= S_DIV;
                    end else begin
                        r_sim   <= 16'sd0;
                        r_state <= S_NEXT;
                    end
                end
                S_DIV: begin
                    if (w_dv_done) begin
                        r_sim   <= w_sat;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_best      <= w_best;
                    r_best_slot <= w_best_slot;
                    if (w_last_ent) begin
                        r_state <= S_IDLE;
                        r_res_v <= 1'b1;
                        if (w_best >= r_thr) begin
                            r_hits <= w_hits_inc;
                            r_res  <= f_res(OUT_HIT, 7'(w_best_slot), w_best,
                                            w_hits_inc, r_misses, r_drops);
                        end else begin
                            r_misses <= w_misses_inc;
                            r_res    <= f_res(OUT_MISS, 7'd0, w_best,
                                              r_hits, w_misses_inc, r_drops);
                        end
                    end else begin
                        r_ent   <= r_ent + 1'b1;
                        r_sbase <= r_sbase + BASE_W'(EMBED_DIM);
                        r_state <= S_SCAN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/cnec_checker.sv]
// Port-level checker of the cosine cache, bound to the top level.
`include "cosine_nearest_entry_cache_top_macros.svh"

module cnec_checker
    import cnec_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input t_req               i_req,
    input logic               busy,
    input logic               o_res_valid,
    input t_res               o_res
);

    `CNEC_ASSERT_NEXT(a_clear_answers, start && !busy && i_req.kind == KIND_CLEAR, o_res_valid && o_res.outcome == OUT_CLEARED && o_res.drop_count == 32'd0)
    `CNEC_ASSERT_NEXT(a_query_last_busy, start && !busy && i_req.kind == KIND_QUERY && i_req.last_element, busy && !o_res_valid)
    `CNEC_ASSERT_NEXT(a_mid_store_quiet, start && !busy && i_req.kind == KIND_STORE && !i_req.last_element, !o_res_valid && !busy)
    `CNEC_ASSERT_NOW(a_stored_slot, o_res_valid && (o_res.outcome == OUT_STORED || o_res.outcome == OUT_HIT), o_res.slot < 7'(CAPACITY))

endmodule

bind cosine_nearest_entry_cache_top cnec_checker u_cnec_checker (.*);

[tb/tb_cosine_nearest_entry_cache_top.sv]
// Testbench for the cosine nearest-entry cache: directed and random requests, predicted results.
module tb_cosine_nearest_entry_cache_top;
    import cnec_pkg::*;

    localparam int  ITEM_TARGET = 800;
    localparam int  SETTLE      = 100;
    localparam longint CYCLE_LIMIT = 6000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    t_req               i_req = '0;
    logic               busy;
    logic               o_res_valid;
    t_res               o_res;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic signed [15:0] i_cfg_data = '0;

    cosine_nearest_entry_cache_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req      (i_req),
        .busy       (busy),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Mirror of the block state, kept by the predictor.
    logic signed [15:0] entry_mem [CAPACITY][EMBED_DIM];
    int                 entry_len [CAPACITY];
    logic signed [15:0] query_mem [EMBED_DIM];
    int                 entries;
    int                 elem_pos;
    logic [31:0]        hits, misses, drops;
    logic signed [15:0] threshold;

    t_res   pending_results [$];
    int     error_count = 0;
    int     requests_sent = 0;
    longint cycle_count = 0;

    // Floor of the square root, one result bit per pass.
    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Q1.15 cosine between the query mirror and one stored entry, rounded and saturated.
    function automatic logic signed [15:0] cosine_to_entry(int e);
        longint d, na, nb;
        longint unsigned den, mag, quo;
        d = 0; na = 0; nb = 0;
        for (int i = 0; i < EMBED_DIM; i++) begin
            d  += longint'(query_mem[i]) * longint'(entry_mem[e][i]);
            na += longint'(query_mem[i]) * longint'(query_mem[i]);
            nb += longint'(entry_mem[e][i]) * longint'(entry_mem[e][i]);
        end
        if (na == 0 || nb == 0) return 16'sd0;
        den = sqrt_floor(na) * sqrt_floor(nb);
        mag = (d < 0) ? longint'(-d) : d;
        quo = (mag * 65536 + den) / (2 * den);
        if (d >= 0) return (quo > 32767) ? 16'sd32767 : 16'(quo);
        if (quo > 32768) quo = 32768;
        return 16'(-longint'(quo));
    endfunction

    // Advance the mirror by one accepted request; queue the result it causes, if any.
    task automatic predict_request(input t_req r);
        t_res               res;
        logic signed [15:0] best, s;
        int                 best_slot;
        res = '0;
        case (r.kind)
            KIND_CLEAR: begin
                entries = 0; drops = 0; elem_pos = 0;
                res.outcome = OUT_CLEARED;
            end
            KIND_STORE: begin
                if (entries < CAPACITY && elem_pos < EMBED_DIM)
                    entry_mem[entries][elem_pos] = r.element_value;
                if (elem_pos < EMBED_DIM) elem_pos++;
                if (!r.last_element) return;
                if (entries >= CAPACITY) begin
                    drops++;
                    res.outcome = OUT_DROPPED;
                    res.slot    = 7'(CAPACITY);
                end else begin
                    for (int i = elem_pos; i < EMBED_DIM; i++) entry_mem[entries][i] = '0;
                    entry_len[entries] = elem_pos;
                    res.outcome = OUT_STORED;
                    res.slot    = 7'(entries);
                    entries++;
                end
                elem_pos = 0;
            end
            KIND_QUERY: begin
                if (elem_pos < EMBED_DIM) begin
                    query_mem[elem_pos] = r.element_value;
                    elem_pos++;
                end
                if (!r.last_element) return;
                for (int i = elem_pos; i < EMBED_DIM; i++) query_mem[i] = '0;
                elem_pos = 0;
                best = SIM_MIN; best_slot = 0;
                for (int e = 0; e < entries; e++) begin
                    s = cosine_to_entry(e);
                    if (s > best) begin
                        best = s; best_slot = e;
                    end
                end
                if (entries > 0 && best >= threshold) begin
                    hits++;
                    res.outcome = OUT_HIT;
                    res.slot    = 7'(best_slot);
                end else begin
                    misses++;
                    res.outcome = OUT_MISS;
                end
                res.similarity = best;
            end
            default: return;
        endcase
        res.hit_count  = hits;
        res.miss_count = misses;
        res.drop_count = drops;
        pending_results.push_back(res);
    endtask

    // Check every result strobe against the oldest prediction.
    always @(posedge i_clk) begin
        t_res want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout at %0t", $time);
            $display("Some tests failed");
            $finish;
        end
        if (i_rst_n && o_res_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_res);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_res.outcome !== want.outcome) begin
                    $display("%0t: outcome exp %0d got %0d", $time, want.outcome, o_res.outcome);
                    error_count++;
                end
                if (o_res.slot !== want.slot) begin
                    $display("%0t: slot exp %0d got %0d", $time, want.slot, o_res.slot);
                    error_count++;
                end
                if (o_res.similarity !== want.similarity) begin
                    $display("%0t: similarity exp %0d got %0d", $time,
                             want.similarity, o_res.similarity);
                    error_count++;
                end
                if (o_res.hit_count !== want.hit_count) begin
                    $display("%0t: hit_count exp %0d got %0d", $time,
                             want.hit_count, o_res.hit_count);
                    error_count++;
                end
                if (o_res.miss_count !== want.miss_count) begin
                    $display("%0t: miss_count exp %0d got %0d", $time,
                             want.miss_count, o_res.miss_count);
                    error_count++;
                end
                if (o_res.drop_count !== want.drop_count) begin
                    $display("%0t: drop_count exp %0d got %0d", $time,
                             want.drop_count, o_res.drop_count);
                    error_count++;
                end
            end
        end
    end

    // Send one request; start stays high so back-to-back requests need no gap.
    task automatic send_request(input logic [1:0] k, input logic signed [15:0] v,
                                input logic l);
        t_req r;
        r.kind = k; r.element_value = v; r.last_element = l;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        predict_request(r);
        requests_sent++;
    endtask

    // Drop start for a random gap one time in four; otherwise keep it high.
    task automatic maybe_gap();
        int gap;
        if ($urandom_range(0, 3) != 0) return;
        gap = $urandom_range(1, 6);
        start <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic send_vector(input logic [1:0] k, input logic signed [15:0] vals[$]);
        foreach (vals[i]) begin
            send_request(k, vals[i], i == vals.size() - 1);
            maybe_gap();
        end
    endtask

    // Hold off until every predicted result has arrived and the block is idle.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic signed [15:0] t);
        drain();
        repeat (80) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= t;
        do @(posedge i_clk); while (!o_cfg_ready);
        threshold = t;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(0, 5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    // Clear, every kind, the unused kind, field extremes and an empty-store query.
    task automatic test_kinds_and_extremes();
        send_request(KIND_CLEAR, 16'sh1234, 1'b0);
        send_vector(KIND_QUERY, '{16'sh7FFF, 16'sh8000});
        send_request(2'd3, 16'sh7FFF, 1'b1);
        send_vector(KIND_STORE, '{16'sh7FFF, 16'sh8000, 16'sh0001});
        send_vector(KIND_STORE, '{16'sh0000, 16'sh0000});
        send_vector(KIND_QUERY, '{16'sh7FFF, 16'sh8000, 16'sh0001});
        // opposite vector saturates at the negative end
        send_vector(KIND_QUERY, '{16'sh8001, 16'sh7FFF, 16'shFFFF});
        send_vector(KIND_QUERY, '{16'sh0000});
        // short vector: remaining positions read as zero
        send_vector(KIND_QUERY, '{16'sh7FFF});
        drain();
    endtask

    // Over-long vectors: elements past the last position are ignored.
    task automatic test_long_vectors();
        logic signed [15:0] v[$];
        for (int i = 0; i < EMBED_DIM + 4; i++) v.push_back(rand_value());
        send_vector(KIND_STORE, v);
        send_vector(KIND_QUERY, v);
        drain();
    endtask

    // Fill the store, overflow it and query the full store, then clear it and query again.
    task automatic test_full_store();
        send_request(KIND_CLEAR, '0, 1'b0);
        for (int i = 0; i < CAPACITY; i++) send_request(KIND_STORE, rand_value(), 1'b1);
        send_vector(KIND_STORE, '{16'sh0100, 16'sh0200});
        send_request(KIND_STORE, 16'sh7FFF, 1'b1);
        send_request(KIND_QUERY, 16'sh4000, 1'b1);
        drain();
        send_request(KIND_CLEAR, '0, 1'b0);
        send_request(KIND_QUERY, 16'sh4000, 1'b1);
        drain();
    endtask

    // Stores and queries, some near stored entries, at a given threshold.
    task automatic threshold_phase(input logic signed [15:0] t, input int n);
        logic signed [15:0] v[$];
        int                 e;
        write_threshold(t);
        for (int q = 0; q < n; q++) begin
            v.delete();
            if (entries > 0 && $urandom_range(0, 1)) begin
                e = $urandom_range(0, entries - 1);
                for (int i = 0; i < entry_len[e]; i++)
                    v.push_back(entry_mem[e][i] + 16'($urandom_range(0, 7)) - 16'sd3);
            end else begin
                for (int i = 0; i < $urandom_range(1, 4); i++) v.push_back(rand_value());
            end
            send_vector($urandom_range(0, 2) == 0 ? KIND_STORE : KIND_QUERY, v);
        end
        drain();
    endtask

    task automatic test_thresholds();
        threshold_phase(16'sh8000, 6);
        threshold_phase(16'sh7FFF, 6);
        threshold_phase(16'sd0, 6);
        threshold_phase(16'($urandom), 6);
    endtask

    // Random mix: mostly well-formed vectors, some noise and cut-off vectors.
    task automatic test_random_traffic(input int n);
        logic signed [15:0] v[$];
        logic [1:0]         k;
        int                 len, e, roll;
        int                 stop;
        stop = requests_sent + n;
        while (requests_sent < stop) begin
            roll = $urandom_range(0, 99);
            if (entries > 12 || roll < 5) begin
                send_request(KIND_CLEAR, 16'($urandom), 1'($urandom));
            end else if (roll < 8) begin
                send_request(2'd3, 16'($urandom), 1'($urandom));
            end else if (roll < 12) begin
                // cut a vector short with a clear
                k = $urandom_range(0, 1) ? KIND_STORE : KIND_QUERY;
                for (int i = 0; i < $urandom_range(1, 5); i++)
                    send_request(k, rand_value(), 1'b0);
                send_request(KIND_CLEAR, '0, 1'b0);
            end else begin
                v.delete();
                k = $urandom_range(0, 99) < 55 ? KIND_STORE : KIND_QUERY;
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, EMBED_DIM + 6)
                                                   : $urandom_range(1, 8);
                if (k == KIND_QUERY && entries > 0 && $urandom_range(0, 1)) begin
                    e = $urandom_range(0, entries - 1);
                    len = entry_len[e];
                    for (int i = 0; i < len; i++)
                        v.push_back(($urandom_range(0, 3) == 0) ? rand_value()
                                                                : entry_mem[e][i]);
                end else begin
                    for (int i = 0; i < len; i++) v.push_back(rand_value());
                end
                send_vector(k, v);
            end
            maybe_gap();
            // wait for every result now and then, then resume
            if ($urandom_range(0, 49) == 0) drain();
        end
        drain();
    endtask

    initial begin
        entries = 0; elem_pos = 0; hits = 0; misses = 0; drops = 0;
        threshold = THR_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_kinds_and_extremes();
        test_long_vectors();
        test_full_store();
        test_thresholds();
        write_threshold(16'sd16384);
        test_random_traffic((ITEM_TARGET - requests_sent) / 2);
        write_threshold(THR_RESET);
        test_random_traffic(ITEM_TARGET - requests_sent);
        repeat (SETTLE) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/cnec_pkg.sv
rtl/core/cnec_sqrt.sv
rtl/core/cnec_div.sv
rtl/core/cosine_nearest_entry_cache_top.sv
rtl/core/cnec_checker.sv
tb/tb_cosine_nearest_entry_cache_top.sv
